// ===== design/gfba_pkg.sv =====
package gfba_pkg;

	// field widths fixed by the item formats
	localparam int WORD_W = 32;
	localparam int IDX_W = 6;

	// default stack depth
	localparam int GROUP_SIZE_DEF = 32;

	// opcodes of an input item
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_FILL = 2'd2;

	// kinds of a result item
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_SPILL = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// error codes carried in the value field
	localparam logic [WORD_W-1:0] ERR_NO_SPACE = 32'd1;
	localparam logic [WORD_W-1:0] ERR_FILL_BUSY = 32'd2;
	localparam logic [WORD_W-1:0] ERR_STRAY_FILL = 32'd3;
	localparam logic [WORD_W-1:0] ERR_ZERO_BLOCK = 32'd4;
	localparam logic [WORD_W-1:0] ERR_BAD_OPCODE = 32'd5;

	typedef struct packed {
		logic [1:0] opcode;
		logic [WORD_W-1:0] word_value;
	} req_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] target_block;
		logic [IDX_W-1:0] word_index;
		logic last;
	} rsp_item_t;

	// shift control shared by every stack cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

// ===== design/gfba_cell.sv =====
module gfba_cell (
	input logic clk,
	input gfba_pkg::cell_ctrl_t ctrl,
	input logic [gfba_pkg::WORD_W-1:0] from_above,
	input logic [gfba_pkg::WORD_W-1:0] from_below,
	output logic [gfba_pkg::WORD_W-1:0] entry
);

	logic [gfba_pkg::WORD_W-1:0] entry_q;

	// push takes the neighbour nearer the top, pop the one further down
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= from_above;
		end else if (ctrl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

// ===== design/grouped_free_block_allocator_unit.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req (opcode, word_value)
// rsp     | out       | rsp_valid, rsp_stall | rsp (kind, value, target, index, last)
//
// Allocate, free with room and fill words need no extra state; an item can be
// taken every cycle while the result register drains and the unit is idle.
// A free on a full stack sends the count word, then the cell row shifts one place
// a cycle while the result register drains, streaming entries out of its deepest cell.
// An allocate that empties the stack returns the block, then loads a read request.
// Reset is asynchronous and leaves an empty stack that awaits a fill record.
// req_stall is high while a group streams out, while the read request waits to
// be loaded, or while the result register is held.
module grouped_free_block_allocator_unit #(
	parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input gfba_pkg::req_item_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output gfba_pkg::rsp_item_t rsp
);

	localparam int CNT_W = $clog2(GROUP_SIZE + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SPILL = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] limit_q;
	logic fill_pending_q;
	logic fill_started_q;
	logic [gfba_pkg::WORD_W-1:0] target_q;
	logic [gfba_pkg::WORD_W-1:0] read_blk_q;
	logic [gfba_pkg::IDX_W-1:0] spill_idx_q;
	logic rsp_valid_q;
	gfba_pkg::rsp_item_t rsp_q;

	logic slot_free;
	logic accept;
	logic [CNT_W-1:0] count_inc;
	logic stack_full;
	gfba_pkg::cell_ctrl_t cell_ctrl;
	logic [gfba_pkg::WORD_W-1:0] push_data;
	logic [gfba_pkg::WORD_W-1:0] cell_q [GROUP_SIZE];
	logic load;
	gfba_pkg::rsp_item_t load_item;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !slot_free;
	assign accept = req_valid && !req_stall;
	assign count_inc = count_q + CNT_W'(1);
	assign stack_full = (count_q == CNT_W'(GROUP_SIZE));

	// row of stack cells, top of stack in cell 0
	for (genvar i = 0; i < GROUP_SIZE; i++) begin : g_cell
		logic [gfba_pkg::WORD_W-1:0] above;
		logic [gfba_pkg::WORD_W-1:0] below;
		if (i == 0) begin : g_top
			assign above = push_data;
		end else begin : g_mid
			assign above = cell_q[i-1];
		end
		if (i == GROUP_SIZE - 1) begin : g_end
			assign below = '0;
		end else begin : g_inner
			assign below = cell_q[i+1];
		end
		gfba_cell u_cell (
			.clk(clk),
			.ctrl(cell_ctrl),
			.from_above(above),
			.from_below(below),
			.entry(cell_q[i])
		);
	end

	// decode of the accepted item and of the streaming states
	always_comb begin
		cell_ctrl = '0;
		push_data = req.word_value;
		load = 1'b0;
		load_item = '0;
		load_item.last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.opcode)
						gfba_pkg::OP_ALLOC: begin
							load = 1'b1;
							if (fill_pending_q) begin
								load_item.kind = gfba_pkg::KIND_ERROR;
								load_item.value = gfba_pkg::ERR_FILL_BUSY;
							end else if (count_q == '0) begin
								load_item.kind = gfba_pkg::KIND_ERROR;
								load_item.value = gfba_pkg::ERR_NO_SPACE;
							end else begin
								cell_ctrl.pop = 1'b1;
								load_item.kind = gfba_pkg::KIND_ALLOC;
								load_item.value = cell_q[0];
								load_item.last = (count_q != CNT_W'(1));
							end
						end
						gfba_pkg::OP_FREE: begin
							if (fill_pending_q) begin
								load = 1'b1;
								load_item.kind = gfba_pkg::KIND_ERROR;
								load_item.value = gfba_pkg::ERR_FILL_BUSY;
							end else if (req.word_value == '0) begin
								load = 1'b1;
								load_item.kind = gfba_pkg::KIND_ERROR;
								load_item.value = gfba_pkg::ERR_ZERO_BLOCK;
							end else if (!stack_full) begin
								cell_ctrl.push = 1'b1;
							end else begin
								// count word opens the spill
								load = 1'b1;
								load_item.kind = gfba_pkg::KIND_SPILL;
								load_item.value = gfba_pkg::WORD_W'(GROUP_SIZE);
								load_item.target_block = req.word_value;
								load_item.last = 1'b0;
							end
						end
						gfba_pkg::OP_FILL: begin
							if (!fill_pending_q) begin
								load = 1'b1;
								load_item.kind = gfba_pkg::KIND_ERROR;
								load_item.value = gfba_pkg::ERR_STRAY_FILL;
							end else if (fill_started_q && req.word_value != '0
									&& !stack_full) begin
								cell_ctrl.push = 1'b1;
							end
						end
						default: begin
							load = 1'b1;
							load_item.kind = gfba_pkg::KIND_ERROR;
							load_item.value = gfba_pkg::ERR_BAD_OPCODE;
						end
					endcase
				end
			end
			ST_SPILL: begin
				// deepest cell leaves, the row moves one place down
				if (slot_free) begin
					load = 1'b1;
					cell_ctrl.push = 1'b1;
					push_data = target_q;
					load_item.kind = gfba_pkg::KIND_SPILL;
					load_item.value = cell_q[GROUP_SIZE-1];
					load_item.target_block = target_q;
					load_item.word_index = spill_idx_q;
					load_item.last = (spill_idx_q == gfba_pkg::IDX_W'(GROUP_SIZE));
				end
			end
			ST_READ: begin
				if (slot_free) begin
					load = 1'b1;
					load_item.kind = gfba_pkg::KIND_READ;
					load_item.value = read_blk_q;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			limit_q <= '0;
			fill_pending_q <= 1'b1;
			fill_started_q <= 1'b0;
			spill_idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.opcode)
							gfba_pkg::OP_ALLOC: begin
								if (!fill_pending_q && count_q != '0) begin
									count_q <= count_q - CNT_W'(1);
									if (count_q == CNT_W'(1)) begin
										state_q <= ST_READ;
										fill_pending_q <= 1'b1;
										fill_started_q <= 1'b0;
										limit_q <= '0;
									end
								end
							end
							gfba_pkg::OP_FREE: begin
								if (!fill_pending_q && req.word_value != '0) begin
									if (!stack_full) begin
										count_q <= count_inc;
									end else begin
										state_q <= ST_SPILL;
										spill_idx_q <= gfba_pkg::IDX_W'(1);
									end
								end
							end
							gfba_pkg::OP_FILL: begin
								if (fill_pending_q) begin
									if (!fill_started_q) begin
										// count word, saturated at the stack depth
										count_q <= '0;
										if (req.word_value > gfba_pkg::WORD_W'(GROUP_SIZE)) begin
											limit_q <= CNT_W'(GROUP_SIZE);
										end else begin
											limit_q <= req.word_value[CNT_W-1:0];
										end
										if (req.word_value == '0) begin
											fill_pending_q <= 1'b0;
										end else begin
											fill_started_q <= 1'b1;
										end
									end else if (req.word_value == '0 || stack_full) begin
										fill_pending_q <= 1'b0;
										fill_started_q <= 1'b0;
									end else begin
										count_q <= count_inc;
										if (count_inc >= limit_q) begin
											fill_pending_q <= 1'b0;
											fill_started_q <= 1'b0;
										end
									end
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SPILL: begin
					if (slot_free) begin
						spill_idx_q <= spill_idx_q + gfba_pkg::IDX_W'(1);
						if (spill_idx_q == gfba_pkg::IDX_W'(GROUP_SIZE)) begin
							state_q <= ST_IDLE;
							count_q <= CNT_W'(1);
						end
					end
				end
				ST_READ: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= load_item;
		end
		if (accept && req.opcode == gfba_pkg::OP_FREE) begin
			target_q <= req.word_value;
		end
		if (accept && req.opcode == gfba_pkg::OP_ALLOC) begin
			read_blk_q <= cell_q[0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ===== test/grouped_free_block_allocator_unit_tb.sv =====
module grouped_free_block_allocator_unit_tb;

	localparam int G = gfba_pkg::GROUP_SIZE_DEF;
	localparam int WW = gfba_pkg::WORD_W;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int RANDOM_ITEMS = 234;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 2 * (G + 1) + 10;

	typedef struct packed {
		logic [1:0] op;
		logic [WW-1:0] word;
		logic typed;
		logic [1:0] kind;
		logic [WW-1:0] value;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	gfba_pkg::req_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	gfba_pkg::rsp_item_t rsp;

	// shadow of the allocator state
	logic [WW-1:0] stk [G];
	int stk_count;
	bit awaiting_fill;
	int fill_pos;
	int fill_lim;

	// results owed by the block, oldest first
	gfba_pkg::rsp_item_t block_results [$];
	dir_row_t dir_rows [$];

	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int stall_tick = 0;
	int stall_mode = 0;
	bit grow = 1'b1;

	grouped_free_block_allocator_unit #(
		.GROUP_SIZE(G)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("** grouped_free_block_allocator_unit: FAILED **");
		$finish;
	end

	task automatic owe(input logic [1:0] k, input logic [WW-1:0] v,
			input logic [WW-1:0] tgt, input int idx, input logic lst);
		gfba_pkg::rsp_item_t r;
		r.kind = k;
		r.value = v;
		r.target_block = tgt;
		r.word_index = gfba_pkg::IDX_W'(idx);
		r.last = lst;
		block_results.push_back(r);
	endtask

	// advance the shadow state by one item and queue what it causes
	task automatic apply_block_op(input gfba_pkg::req_item_t it);
		logic [WW-1:0] w;
		w = it.word_value;
		case (it.opcode)
			gfba_pkg::OP_ALLOC: begin
				if (awaiting_fill)
					owe(gfba_pkg::KIND_ERROR, gfba_pkg::ERR_FILL_BUSY, '0, 0, 1'b1);
				else if (stk_count == 0)
					owe(gfba_pkg::KIND_ERROR, gfba_pkg::ERR_NO_SPACE, '0, 0, 1'b1);
				else begin
					stk_count--;
					if (stk_count != 0) begin
						owe(gfba_pkg::KIND_ALLOC, stk[stk_count], '0, 0, 1'b1);
					end else begin
						// stack ran dry: ask for the group held in that block
						owe(gfba_pkg::KIND_ALLOC, stk[0], '0, 0, 1'b0);
						owe(gfba_pkg::KIND_READ, stk[0], '0, 0, 1'b1);
						awaiting_fill = 1'b1;
						fill_pos = 0;
						fill_lim = 0;
					end
				end
			end
			gfba_pkg::OP_FREE: begin
				if (awaiting_fill)
					owe(gfba_pkg::KIND_ERROR, gfba_pkg::ERR_FILL_BUSY, '0, 0, 1'b1);
				else if (w == '0)
					owe(gfba_pkg::KIND_ERROR, gfba_pkg::ERR_ZERO_BLOCK, '0, 0, 1'b1);
				else if (stk_count < G) begin
					stk[stk_count] = w;
					stk_count++;
				end else begin
					// full stack spills into the freed block
					owe(gfba_pkg::KIND_SPILL, WW'(G), w, 0, 1'b0);
					for (int i = 0; i < G; i++)
						owe(gfba_pkg::KIND_SPILL, stk[i], w, i + 1, (i + 1 == G));
					stk[0] = w;
					stk_count = 1;
				end
			end
			gfba_pkg::OP_FILL: begin
				if (!awaiting_fill)
					owe(gfba_pkg::KIND_ERROR, gfba_pkg::ERR_STRAY_FILL, '0, 0, 1'b1);
				else if (fill_pos == 0) begin
					fill_lim = (w > G) ? G : int'(w);
					stk_count = 0;
					if (fill_lim == 0)
						awaiting_fill = 1'b0;
					else
						fill_pos = 1;
				end else if (w == '0 || stk_count >= G) begin
					awaiting_fill = 1'b0;
					fill_pos = 0;
				end else begin
					stk[stk_count] = w;
					stk_count++;
					fill_pos++;
					if (stk_count >= fill_lim) begin
						awaiting_fill = 1'b0;
						fill_pos = 0;
					end
				end
			end
			default: owe(gfba_pkg::KIND_ERROR, gfba_pkg::ERR_BAD_OPCODE, '0, 0, 1'b1);
		endcase
	endtask

	// send one item, opening a new burst after a gap when the last one is used up
	task automatic send_item(input gfba_pkg::req_item_t it);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		while (block_results.size() != 0) @(posedge clk);
	endtask

	function automatic dir_row_t row(input logic [1:0] op, input logic [WW-1:0] w,
			input logic typed = 1'b0, input logic [1:0] k = gfba_pkg::KIND_ALLOC,
			input logic [WW-1:0] v = '0);
		dir_row_t d;
		d.op = op;
		d.word = w;
		d.typed = typed;
		d.kind = k;
		d.value = v;
		return d;
	endfunction

	// random item, mostly well-formed for the current state
	function automatic gfba_pkg::req_item_t pick_item();
		gfba_pkg::req_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.word_value = $urandom;
		if (r < 6) begin
			// noise: any opcode, often with a zero word
			it.opcode = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 1) == 0)
				it.word_value = '0;
		end else if (awaiting_fill) begin
			it.opcode = gfba_pkg::OP_FILL;
			if (fill_pos == 0) begin
				case ($urandom_range(0, 9))
					0: it.word_value = '0;
					1: it.word_value = $urandom;
					2, 3, 4: it.word_value = $urandom_range(G - 4, G + 8);
					default: it.word_value = $urandom_range(1, 8);
				endcase
			end else if ($urandom_range(0, 19) == 0)
				it.word_value = '0;
			else if (it.word_value == '0)
				it.word_value = 1;
		end else begin
			r = $urandom_range(0, 99);
			it.opcode = (grow ? (r < 80) : (r < 30)) ? gfba_pkg::OP_FREE
				: gfba_pkg::OP_ALLOC;
			if (it.word_value == '0)
				it.word_value = 100;
		end
		return it;
	endfunction

	task automatic note_mismatch(input gfba_pkg::rsp_item_t want,
			input gfba_pkg::rsp_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"mismatch @%0d: kind %0d/%0d value %h/%h target %h/%h",
				" idx %0d/%0d last %b/%b"},
				cycle_count, want.kind, got.kind, want.value, got.value,
				want.target_block, got.target_block, want.word_index, got.word_index,
				want.last, got.last);
	endtask

	// result check, done just after the edge so queue updates have settled
	always @(posedge clk) begin : rsp_check
		gfba_pkg::rsp_item_t got;
		gfba_pkg::rsp_item_t want;
		logic hit;
		hit = arst_n && rsp_valid && !rsp_stall;
		got = rsp;
		#1;
		if (hit) begin
			if (block_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result @%0d: kind %0d value %h", cycle_count,
						got.kind, got.value);
			end else begin
				want = block_results.pop_front();
				if (got.kind !== want.kind || got.value !== want.value
						|| got.target_block !== want.target_block
						|| got.word_index !== want.word_index || got.last !== want.last)
					note_mismatch(want, got);
			end
		end
	end

	// receiver stall pattern, switching at random among four modes
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 50 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 99) < 30);
			2: rsp_stall <= ($urandom_range(0, 99) < 70);
			default: rsp_stall <= ((stall_tick % 9) < 4);
		endcase
	end

	initial begin : stimulus
		gfba_pkg::req_item_t it;
		int owed_before;

		for (int i = 0; i < G; i++)
			stk[i] = '0;
		stk_count = 0;
		awaiting_fill = 1'b1;
		fill_pos = 0;
		fill_lim = 0;

		// directed items: special cases and field extremes
		dir_rows.push_back(row(gfba_pkg::OP_ALLOC, '0, 1'b1,
			gfba_pkg::KIND_ERROR, gfba_pkg::ERR_FILL_BUSY));
		dir_rows.push_back(row(gfba_pkg::OP_FREE, 32'd5, 1'b1,
			gfba_pkg::KIND_ERROR, gfba_pkg::ERR_FILL_BUSY));
		dir_rows.push_back(row(OP_UNKNOWN, 32'hFFFF_FFFF, 1'b1,
			gfba_pkg::KIND_ERROR, gfba_pkg::ERR_BAD_OPCODE));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'd3));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'hFFFF_FFFF));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'h0000_0001));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'h8000_0000));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'd7, 1'b1,
			gfba_pkg::KIND_ERROR, gfba_pkg::ERR_STRAY_FILL));
		dir_rows.push_back(row(gfba_pkg::OP_FREE, '0, 1'b1,
			gfba_pkg::KIND_ERROR, gfba_pkg::ERR_ZERO_BLOCK));
		dir_rows.push_back(row(OP_UNKNOWN, '0, 1'b1,
			gfba_pkg::KIND_ERROR, gfba_pkg::ERR_BAD_OPCODE));
		dir_rows.push_back(row(gfba_pkg::OP_ALLOC, '0, 1'b1,
			gfba_pkg::KIND_ALLOC, 32'h8000_0000));
		dir_rows.push_back(row(gfba_pkg::OP_ALLOC, '0, 1'b1,
			gfba_pkg::KIND_ALLOC, 32'h0000_0001));
		dir_rows.push_back(row(gfba_pkg::OP_ALLOC, '0));
		dir_rows.push_back(row(gfba_pkg::OP_ALLOC, '0, 1'b1,
			gfba_pkg::KIND_ERROR, gfba_pkg::ERR_FILL_BUSY));
		// zero count ends the fill with nothing on the stack
		dir_rows.push_back(row(gfba_pkg::OP_FILL, '0));
		dir_rows.push_back(row(gfba_pkg::OP_ALLOC, '0, 1'b1,
			gfba_pkg::KIND_ERROR, gfba_pkg::ERR_NO_SPACE));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'd9, 1'b1,
			gfba_pkg::KIND_ERROR, gfba_pkg::ERR_STRAY_FILL));
		dir_rows.push_back(row(gfba_pkg::OP_FREE, 32'd100));
		dir_rows.push_back(row(gfba_pkg::OP_ALLOC, '0));
		// oversized count, then a zero entry cuts the record short
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'd100));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'd9));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, '0));
		dir_rows.push_back(row(gfba_pkg::OP_ALLOC, '0));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'hFFFF_FFFF));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, 32'hA5A5_5A5A));
		dir_rows.push_back(row(gfba_pkg::OP_FILL, '0));

		// reset
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[n]) begin
			it.opcode = dir_rows[n].op;
			it.word_value = dir_rows[n].word;
			send_item(it);
			owed_before = block_results.size();
			apply_block_op(it);
			if (dir_rows[n].typed) begin
				while (block_results.size() > owed_before)
					void'(block_results.pop_back());
				owe(dir_rows[n].kind, dir_rows[n].value, '0, 0, 1'b1);
			end
		end

		// hold off until the directed results are all in
		req_valid <= 1'b0;
		burst_left = 0;
		wait_drained();

		// random items
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 19) == 0)
				grow = !grow;
			if ($urandom_range(0, 39) == 0) begin
				req_valid <= 1'b0;
				burst_left = 0;
				wait_drained();
			end
			it = pick_item();
			send_item(it);
			apply_block_op(it);
		end
		req_valid <= 1'b0;

		// drain
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		#2;
		if (mismatches == 0 && block_results.size() == 0)
			$display("** grouped_free_block_allocator_unit: PASSED **");
		else
			$display("** grouped_free_block_allocator_unit: FAILED **");
		$finish;
	end

endmodule
